// ===== rtl/puf_kbr_pkg.sv =====
// package with shared types and constants for the key bit reconstruction block
`timescale 1ns / 1ps

package puf_kbr_pkg;

   // field widths fixed by the item formats
   localparam int RESP_ADDR_W  = 6;
   localparam int BYTE_W       = 8;
   localparam int LOCKER_W     = 8;
   localparam int LOCK_SLOT_W  = 4;
   localparam int TAP_SLOT_W   = 3;
   localparam int BIT_ADDR_W   = 9;
   localparam int BIT_SEL_W    = 3;
   localparam int LOCK_CNT_W   = 5;
   localparam int TAP_CNT_W    = 4;
   localparam int KEY_LEN_W    = 9;
   localparam int KEY_POS_W    = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 9;

   // register reset values
   localparam logic [LOCK_CNT_W-1:0] LOCK_COUNT_RST    = 5'd5;
   localparam logic [TAP_CNT_W-1:0]  TAPS_PER_LOCK_RST = 4'd3;
   localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_RST    = 9'd128;
   localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_MAX    = 9'd256;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPS_PER_LOCK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH    = 2'd2;

   typedef enum logic [1:0] {
      ACT_RESP_WR = 2'd0,
      ACT_LOCK_WR = 2'd1,
      ACT_TAP_WR  = 2'd2,
      ACT_RECON   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DRAIN,
      SEQ_DONE
   } seq_state_type;

   // one read beat of the reconstruct sweep
   typedef struct packed {
      logic live;
      logic first;
      logic tap;
      logic last;
      logic valid;
   } beat_type;

   typedef struct packed {
      logic resp_we;
      logic lock_we;
      logic tap_we;
   } mem_we_type;

   typedef struct packed {
      logic idle;
      logic start;
      logic load;
   } seq_ctl_type;

endpackage

// ===== rtl/puf_kbr_store.sv =====
// response, lock bit and tap address memories with registered reads
`timescale 1ns / 1ps

module puf_kbr_store #(
   parameter int RESP_DEPTH = 64,
   parameter int LOCK_DEPTH = 4096,
   parameter int TAP_DEPTH  = 32768,
   parameter int RESP_AW    = 6,
   parameter int LOCK_AW    = 12,
   parameter int TAP_AW     = 15
) (
   input  logic                                clock,
   input  puf_kbr_pkg::mem_we_type             we,
   input  logic [RESP_AW-1:0]                  resp_wr_addr,
   input  logic [puf_kbr_pkg::BYTE_W-1:0]      resp_wr_data,
   input  logic [LOCK_AW-1:0]                  lock_wr_addr,
   input  logic                                lock_wr_data,
   input  logic [TAP_AW-1:0]                   tap_wr_addr,
   input  logic [puf_kbr_pkg::BIT_ADDR_W-1:0]  tap_wr_data,
   input  logic [RESP_AW-1:0]                  resp_rd_addr,
   input  logic [LOCK_AW-1:0]                  lock_rd_addr,
   input  logic [TAP_AW-1:0]                   tap_rd_addr,
   output logic [puf_kbr_pkg::BYTE_W-1:0]      resp_rd_q,
   output logic                                lock_rd_q,
   output logic [puf_kbr_pkg::BIT_ADDR_W-1:0]  tap_rd_q
);
   import puf_kbr_pkg::*;

   logic [BYTE_W-1:0]     resp_mem [RESP_DEPTH];
   logic                  lock_mem [LOCK_DEPTH];
   logic [BIT_ADDR_W-1:0] tap_mem  [TAP_DEPTH];

   logic [BYTE_W-1:0]     resp_q_ff;
   logic                  lock_q_ff;
   logic [BIT_ADDR_W-1:0] tap_q_ff;

   always_ff @(posedge clock) begin
      if (we.resp_we) begin
         resp_mem[resp_wr_addr] <= resp_wr_data;
      end
      resp_q_ff <= resp_mem[resp_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.lock_we) begin
         lock_mem[lock_wr_addr] <= lock_wr_data;
      end
      lock_q_ff <= lock_mem[lock_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.tap_we) begin
         tap_mem[tap_wr_addr] <= tap_wr_data;
      end
      tap_q_ff <= tap_mem[tap_rd_addr];
   end

   assign resp_rd_q = resp_q_ff;
   assign lock_rd_q = lock_q_ff;
   assign tap_rd_q  = tap_q_ff;

endmodule

// ===== rtl/puf_kbr_seq.sv =====
// sequencer that sweeps the locks and taps of one locker
`timescale 1ns / 1ps

module puf_kbr_seq #(
   parameter int MAX_LOCKS    = 16,
   parameter int MAX_TAPS     = 8,
   parameter int LOCKER_DEPTH = 256,
   parameter int LOCK_AW      = 12,
   parameter int TAP_AW       = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [1:0]                          req_action,
   input  logic [puf_kbr_pkg::LOCKER_W-1:0]    req_locker_index,
   input  logic [puf_kbr_pkg::LOCK_CNT_W-1:0]  lock_count,
   input  logic [puf_kbr_pkg::TAP_CNT_W-1:0]   taps_per_lock,
   input  logic                                out_free,
   output puf_kbr_pkg::seq_ctl_type            ctl,
   output puf_kbr_pkg::beat_type               beat,
   output logic [LOCK_AW-1:0]                  lock_rd_addr,
   output logic [TAP_AW-1:0]                   tap_rd_addr,
   output logic [puf_kbr_pkg::LOCK_CNT_W-1:0]  eff_locks
);
   import puf_kbr_pkg::*;

   seq_state_type         state_ff, state_in;
   logic                  drain_ff, drain_in;
   logic [LOCK_CNT_W-1:0] lock_ff, lock_in;
   logic [TAP_CNT_W-1:0]  tap_ff, tap_in;
   logic [LOCK_CNT_W-1:0] locks_ff, locks_in;
   logic [TAP_CNT_W-1:0]  taps_ff, taps_in;
   logic [LOCK_AW-1:0]    base_ff, base_in;
   logic                  valid_ff, valid_in;

   logic                  locker_ok;
   logic [LOCK_CNT_W-1:0] locks_sat;
   logic [TAP_CNT_W-1:0]  taps_sat;
   logic                  beat_last;

   // saturate the counts to the store geometry
   assign locks_sat = ({2'b0, lock_count} > 7'(MAX_LOCKS)) ? LOCK_CNT_W'(MAX_LOCKS) : lock_count;
   assign taps_sat  = ({2'b0, taps_per_lock} > 6'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS) : taps_per_lock;
   assign locker_ok = {1'b0, req_locker_index} < 9'(LOCKER_DEPTH);

   assign lock_rd_addr = base_ff + LOCK_AW'(lock_ff);
   assign tap_rd_addr  = TAP_AW'(lock_rd_addr) * TAP_AW'(MAX_TAPS) + TAP_AW'(tap_ff);
   assign beat_last    = (taps_ff == '0) || (tap_ff == taps_ff - 4'd1);
   assign eff_locks    = locks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      lock_ff  <= lock_in;
      tap_ff   <= tap_in;
      locks_ff <= locks_in;
      taps_ff  <= taps_in;
      base_ff  <= base_in;
      valid_ff <= valid_in;
   end

   always_comb begin
      state_in  = state_ff;
      drain_in  = drain_ff;
      lock_in   = lock_ff;
      tap_in    = tap_ff;
      locks_in  = locks_ff;
      taps_in   = taps_ff;
      base_in   = base_ff;
      valid_in  = valid_ff;
      beat      = '0;
      ctl.idle  = 1'b0;
      ctl.start = 1'b0;
      ctl.load  = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            ctl.idle = 1'b1;
            if (req_valid && (req_action == ACT_RECON)) begin
               ctl.start = 1'b1;
               lock_in   = '0;
               tap_in    = '0;
               drain_in  = 1'b0;
               locks_in  = locks_sat;
               taps_in   = taps_sat;
               valid_in  = locker_ok;
               base_in   = locker_ok ? LOCK_AW'(req_locker_index) * LOCK_AW'(MAX_LOCKS) : '0;
               state_in  = (locks_sat == '0) ? SEQ_DRAIN : SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            beat.live  = 1'b1;
            beat.first = (tap_ff == '0);
            beat.tap   = (taps_ff != '0);
            beat.last  = beat_last;
            beat.valid = valid_ff;
            if (beat_last) begin
               tap_in  = '0;
               lock_in = lock_ff + 5'd1;
               if (lock_ff == locks_ff - 5'd1) begin
                  state_in = SEQ_DRAIN;
                  drain_in = 1'b0;
               end
            end else begin
               tap_in = tap_ff + 4'd1;
            end
         end
         SEQ_DRAIN: begin
            // two read stages still in flight
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (out_free) begin
               ctl.load = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/puf_kbr_vote.sv =====
// read pipeline that xors the taps of each lock and counts the ones
`timescale 1ns / 1ps

module puf_kbr_vote #(
   parameter int RESP_DEPTH = 64,
   parameter int RESP_AW    = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  puf_kbr_pkg::beat_type               beat,
   input  logic                                lock_rd_q,
   input  logic [puf_kbr_pkg::BIT_ADDR_W-1:0]  tap_rd_q,
   input  logic [puf_kbr_pkg::BYTE_W-1:0]      resp_rd_q,
   output logic [RESP_AW-1:0]                  resp_rd_addr,
   output logic [puf_kbr_pkg::LOCK_CNT_W-1:0]  ones
);
   import puf_kbr_pkg::*;

   beat_type              s1_ff;
   beat_type              s2_ff;
   logic [BIT_SEL_W-1:0]  s2_sel_ff;
   logic                  s2_inrange_ff;
   logic                  s2_lock_ff;
   logic                  acc_ff, acc_in;
   logic [LOCK_CNT_W-1:0] ones_ff, ones_in;

   logic [BIT_ADDR_W-1:0]               tap_addr;
   logic [BIT_ADDR_W-BIT_SEL_W-1:0]     byte_idx;
   logic                                inrange;
   logic                                resp_bit;

   // stage 1: tap address back, fetch the response byte
   // an out of range locker reads every tap as address zero
   assign tap_addr     = s1_ff.valid ? tap_rd_q : '0;
   assign byte_idx     = tap_addr[BIT_ADDR_W-1:BIT_SEL_W];
   assign inrange      = {1'b0, byte_idx} < 7'(RESP_DEPTH);
   assign resp_rd_addr = byte_idx[RESP_AW-1:0];

   // stage 2: pick the bit and fold it in
   assign resp_bit = s2_ff.tap & s2_inrange_ff & resp_rd_q[s2_sel_ff];

   always_comb begin
      acc_in  = (s2_ff.first ? s2_lock_ff : acc_ff) ^ resp_bit;
      ones_in = ones_ff;
      if (start) begin
         ones_in = '0;
      end else if (s2_ff.live && s2_ff.last) begin
         ones_in = ones_ff + LOCK_CNT_W'(acc_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         ones_ff <= '0;
      end else begin
         s1_ff   <= beat;
         s2_ff   <= s1_ff;
         ones_ff <= ones_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_sel_ff     <= tap_addr[BIT_SEL_W-1:0];
      s2_inrange_ff <= inrange;
      s2_lock_ff    <= s1_ff.valid & lock_rd_q;
      if (s2_ff.live) begin
         acc_ff <= acc_in;
      end
   end

   assign ones = ones_ff;

endmodule

// ===== rtl/puf_locker_key_bit_reconstruct.sv =====
// top level of the key bit reconstruction block: registers, stores, sweep, result
// write beats leave the sequencer idle; the next beat is taken in the following cycle
// a reconstruct beat sweeps locks * max(taps, 1) tap reads (locks, taps saturated)
// at one tap read per cycle, drains the read stages and loads the result once the
// output register is free; a new beat is taken once the result sits in that register
// reset: lock_count 5, taps_per_lock 3, key_length 128, key position 0, no result held
// the memories are not cleared and read undefined until written
`timescale 1ns / 1ps

module puf_locker_key_bit_reconstruct #(
   parameter int RESPONSE_BYTES = 64,
   parameter int LOCKER_COUNT   = 256,
   parameter int MAX_LOCKS      = 16,
   parameter int MAX_TAPS       = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_action,
   input  logic [puf_kbr_pkg::RESP_ADDR_W-1:0]  req_response_addr,
   input  logic [puf_kbr_pkg::BYTE_W-1:0]       req_response_byte,
   input  logic [puf_kbr_pkg::LOCKER_W-1:0]     req_locker_index,
   input  logic [puf_kbr_pkg::LOCK_SLOT_W-1:0]  req_lock_slot,
   input  logic [puf_kbr_pkg::TAP_SLOT_W-1:0]   req_tap_slot,
   input  logic                                 req_lock_value,
   input  logic [puf_kbr_pkg::BIT_ADDR_W-1:0]   req_tap_bit_addr,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_key_bit,
   output logic [puf_kbr_pkg::KEY_POS_W-1:0]    rsp_key_position,
   output logic                                 rsp_last_bit,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [puf_kbr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [puf_kbr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import puf_kbr_pkg::*;

   // only the first 64 bytes and 256 lockers are reachable by the item fields
   localparam int RespDepth   = (RESPONSE_BYTES < 64) ? RESPONSE_BYTES : 64;
   localparam int LockerDepth = (LOCKER_COUNT < 256) ? LOCKER_COUNT : 256;
   localparam int LockDepth   = LockerDepth * MAX_LOCKS;
   localparam int TapDepth    = LockDepth * MAX_TAPS;
   localparam int RespAw      = (RespDepth > 1) ? $clog2(RespDepth) : 1;
   localparam int LockAw      = (LockDepth > 1) ? $clog2(LockDepth) : 1;
   localparam int TapAw       = (TapDepth > 1) ? $clog2(TapDepth) : 1;

   // configuration registers
   logic [LOCK_CNT_W-1:0] lock_count_ff;
   logic [TAP_CNT_W-1:0]  taps_per_lock_ff;
   logic [KEY_LEN_W-1:0]  key_length_ff;

   // key position and output register
   logic [KEY_POS_W-1:0]  key_cnt_ff, key_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_key_bit_ff;
   logic [KEY_POS_W-1:0]  rsp_pos_ff;
   logic                  rsp_last_ff;

   seq_ctl_type           ctl;
   beat_type              beat;
   mem_we_type            we;
   logic                  accept;
   logic                  out_free;
   logic                  lock_ok;
   logic                  tap_ok;
   logic [LockAw-1:0]     lock_wr_addr;
   logic [TapAw-1:0]      tap_wr_addr;
   logic [LockAw-1:0]     lock_rd_addr;
   logic [TapAw-1:0]      tap_rd_addr;
   logic [RespAw-1:0]     resp_rd_addr;
   logic [BYTE_W-1:0]     resp_rd_q;
   logic                  lock_rd_q;
   logic [BIT_ADDR_W-1:0] tap_rd_q;
   logic [LOCK_CNT_W-1:0] ones;
   logic [LOCK_CNT_W-1:0] eff_locks;
   logic [KEY_POS_W-1:0]  len_m1;
   logic                  key_bit;
   logic                  last_in;

   // config writes must be issued only while idle (unenforced); port never pushes back
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_count_ff    <= LOCK_COUNT_RST;
         taps_per_lock_ff <= TAPS_PER_LOCK_RST;
         key_length_ff    <= KEY_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOCK_COUNT:    lock_count_ff    <= csr_wdata[LOCK_CNT_W-1:0];
            CSR_TAPS_PER_LOCK: taps_per_lock_ff <= csr_wdata[TAP_CNT_W-1:0];
            CSR_KEY_LENGTH:    key_length_ff    <= csr_wdata[KEY_LEN_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // a beat is taken only while the sequencer is idle
   assign req_stall = !ctl.idle;
   assign accept    = req_valid && ctl.idle;

   // write beats land in the stores at the accepting edge
   // writes outside a store's geometry are dropped
   assign lock_ok = ({1'b0, req_locker_index} < 9'(LockerDepth)) &&
                    ({3'b0, req_lock_slot} < 7'(MAX_LOCKS));
   assign tap_ok  = lock_ok && ({3'b0, req_tap_slot} < 6'(MAX_TAPS));

   assign we.resp_we = accept && (req_action == ACT_RESP_WR) &&
                       ({1'b0, req_response_addr} < 7'(RespDepth));
   assign we.lock_we = accept && (req_action == ACT_LOCK_WR) && lock_ok;
   assign we.tap_we  = accept && (req_action == ACT_TAP_WR) && tap_ok;

   assign lock_wr_addr = LockAw'(req_locker_index) * LockAw'(MAX_LOCKS) + LockAw'(req_lock_slot);
   assign tap_wr_addr  = TapAw'(lock_wr_addr) * TapAw'(MAX_TAPS) + TapAw'(req_tap_slot);

   puf_kbr_store #(
      .RESP_DEPTH (RespDepth),
      .LOCK_DEPTH (LockDepth),
      .TAP_DEPTH  (TapDepth),
      .RESP_AW    (RespAw),
      .LOCK_AW    (LockAw),
      .TAP_AW     (TapAw)
   ) u_store (
      .clock        (clock),
      .we           (we),
      .resp_wr_addr (req_response_addr[RespAw-1:0]),
      .resp_wr_data (req_response_byte),
      .lock_wr_addr (lock_wr_addr),
      .lock_wr_data (req_lock_value),
      .tap_wr_addr  (tap_wr_addr),
      .tap_wr_data  (req_tap_bit_addr),
      .resp_rd_addr (resp_rd_addr),
      .lock_rd_addr (lock_rd_addr),
      .tap_rd_addr  (tap_rd_addr),
      .resp_rd_q    (resp_rd_q),
      .lock_rd_q    (lock_rd_q),
      .tap_rd_q     (tap_rd_q)
   );

   // sweep: one lock-bit and tap-address read per cycle
   puf_kbr_seq #(
      .MAX_LOCKS    (MAX_LOCKS),
      .MAX_TAPS     (MAX_TAPS),
      .LOCKER_DEPTH (LockerDepth),
      .LOCK_AW      (LockAw),
      .TAP_AW       (TapAw)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_action       (req_action),
      .req_locker_index (req_locker_index),
      .lock_count       (lock_count_ff),
      .taps_per_lock    (taps_per_lock_ff),
      .out_free         (out_free),
      .ctl              (ctl),
      .beat             (beat),
      .lock_rd_addr     (lock_rd_addr),
      .tap_rd_addr      (tap_rd_addr),
      .eff_locks        (eff_locks)
   );

   // tap address -> response byte -> bit, two read stages
   puf_kbr_vote #(
      .RESP_DEPTH (RespDepth),
      .RESP_AW    (RespAw)
   ) u_vote (
      .clock        (clock),
      .reset        (reset),
      .start        (ctl.start),
      .beat         (beat),
      .lock_rd_q    (lock_rd_q),
      .tap_rd_q     (tap_rd_q),
      .resp_rd_q    (resp_rd_q),
      .resp_rd_addr (resp_rd_addr),
      .ones         (ones)
   );

   // strict majority, a tie gives zero
   assign key_bit = ones > (eff_locks >> 1);

   // last position of the key: zero length acts as one, above 256 acts as 256
   always_comb begin
      if (key_length_ff == '0) begin
         len_m1 = '0;
      end else if (key_length_ff > KEY_LENGTH_MAX) begin
         len_m1 = '1;
      end else begin
         len_m1 = KEY_POS_W'(key_length_ff - 9'd1);
      end
   end

   assign last_in  = key_cnt_ff >= len_m1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      key_cnt_in   = key_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load) begin
         key_cnt_in   = last_in ? '0 : key_cnt_ff + 8'd1;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_cnt_ff   <= key_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_key_bit_ff <= key_bit;
         rsp_pos_ff     <= key_cnt_ff;
         rsp_last_ff    <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_bit      = rsp_key_bit_ff;
   assign rsp_key_position = rsp_pos_ff;
   assign rsp_last_bit     = rsp_last_ff;

   // a reconstruct beat keeps the request side blocked on the next cycle
   a_recon_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_action == ACT_RECON)) |=> req_stall)
      else $error("request side open right after a reconstruct beat");

   // the vote count never exceeds the number of locks swept
   a_ones_bounded : assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (ones <= eff_locks))
      else $error("vote count above lock count");

   // the key position wraps to zero after the last bit
   a_key_wrap : assert property (@(posedge clock) disable iff (reset)
      (ctl.load && last_in) |=> (key_cnt_ff == '0))
      else $error("key position did not wrap after last bit");

   // a result is only loaded into a free output register
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> out_free)
      else $error("result loaded over a held beat");

endmodule
